// ===== sv/piwa_pkg.sv =====
// Shared widths, register codes and constants of the windowed-integral PI controller.
`timescale 1ns / 1ps
`default_nettype none
package piwa_pkg;

  localparam int REF_W   = 7;
  localparam int COUNT_W = 20;
  localparam int GAIN_W  = 24;
  localparam int ERR_W   = 8;
  localparam int DRIVE_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Scaled count: count * 100 never exceeds 27 bits.
  localparam int NUM_W = COUNT_W + 7;

  localparam logic [6:0] PERCENT_FULL = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN   = 2'd2;

  localparam logic [COUNT_W-1:0] FULL_SCALE_RST = 20'd1048575;
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 24'd196608;
  localparam logic [GAIN_W-1:0]  INT_GAIN_RST   = 24'd16777;

  // 100 in Q.24.
  localparam logic [31:0] LIMIT_Q24 = 32'd1677721600;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sd25600;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -16'sd25600;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_ERR  = 5'b00100,
    ST_MULI = 5'b01000,
    ST_EVAL = 5'b10000
  } piwa_state_t;

endpackage
`default_nettype wire

// ===== sv/piwa_if.sv =====
// Valid/ready channel interfaces for controller samples and results.
`timescale 1ns / 1ps
`default_nettype none
interface piwa_in_if;
  import piwa_pkg::*;
  logic               valid;
  logic               ready;
  logic [REF_W-1:0]   reference;
  logic [COUNT_W-1:0] encoder_count;
  modport source (output valid, output reference, output encoder_count, input ready);
  modport sink (input valid, input reference, input encoder_count, output ready);
endinterface

interface piwa_out_if;
  import piwa_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      saturated;
  modport source (output valid, output drive, output saturated, input ready);
  modport sink (input valid, input drive, input saturated, output ready);
endinterface
`default_nettype wire

// ===== sv/pi_windowed_integral_antiwindup_core.sv =====
// Top level of the windowed-integral PI position controller with anti-windup.
// A sample transfer yields its result after the bit-serial divider that scales the encoder
//   count, then the error, multiply and evaluation states.
// A new sample is taken only in the idle state, once the previous result has been loaded.
// Reset clears the controller state, the window sum, the write pointer and the ring's
//   per-entry valid bits, so the ring reads as all zero at once; registers return to defaults.
`timescale 1ns / 1ps
`default_nettype none
module pi_windowed_integral_antiwindup_core #(
  parameter int WINDOW_DEPTH = 50
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  piwa_in_if.sink                              sample,
  piwa_out_if.source                           result,
  input  wire logic                            cfg_we,
  input  wire logic [piwa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [piwa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import piwa_pkg::*;

  // Ring pointer width, and a window sum wide enough for a full ring of extreme errors.
  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W = IDX_W + ERR_W;
  localparam int P_W   = GAIN_W + 1 + ERR_W;
  localparam int I_W   = GAIN_W + 1 + SUM_W;
  localparam int U_W   = ((P_W + 8 > I_W) ? P_W + 8 : I_W) + 1;

  // Configuration registers, written only while the controller is idle: user rule, unchecked.
  logic [COUNT_W-1:0] full_scale;
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  int_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FULL_SCALE_RST;
      prop_gain  <= PROP_GAIN_RST;
      int_gain   <= INT_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FULL_SCALE: full_scale <= cfg_data[COUNT_W-1:0];
        CFG_PROP_GAIN:  prop_gain  <= cfg_data[GAIN_W-1:0];
        CFG_INT_GAIN:   int_gain   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  piwa_state_t state;
  piwa_state_t state_next;

  logic sample_xfer;
  logic result_xfer;
  logic out_free;

  assign sample.ready = (state == ST_IDLE);
  assign sample_xfer  = sample.valid && sample.ready;
  assign result_xfer  = result.valid && result.ready;
  // The output register may be reloaded once its previous result has been transferred.
  assign out_free     = !result.valid || result.ready;

  // A full scale of zero behaves as one.
  logic [COUNT_W-1:0] div_den;
  logic [NUM_W-1:0]   div_num;
  logic               div_busy;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;

  assign div_den = (full_scale == '0) ? COUNT_W'(1) : full_scale;
  assign div_num = NUM_W'(sample.encoder_count) * NUM_W'(PERCENT_FULL);

  piwa_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (sample_xfer),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Error ring: a synchronous memory with a registered read. The entry at the write
  // pointer is read when the sample is transferred and rewritten when the result is formed.
  // Each entry has a valid bit that reset clears; an entry never written reads as zero.
  logic signed [ERR_W-1:0] ring [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] ring_valid;
  logic [IDX_W-1:0]        write_index;
  logic signed [ERR_W-1:0] ring_rd;
  logic                    ring_rd_valid;
  logic                    ring_we;
  logic signed [ERR_W-1:0] ring_wdata;
  logic signed [ERR_W-1:0] old_err;

  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      ring_rd       <= ring[write_index];
      ring_rd_valid <= ring_valid[write_index];
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[write_index] <= ring_wdata;
    end
  end

  assign old_err = ring_rd_valid ? ring_rd : '0;

  // Datapath registers.
  logic [REF_W-1:0]        ref_q;
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] err_next;
  logic [6:0]              position;
  logic signed [SUM_W-1:0] window_sum;
  logic signed [P_W-1:0]   prod_p;
  logic signed [I_W-1:0]   prod_i;

  // The position is the quotient saturated at 100 percent. Reference up to 127 minus a
  // position of 0..100 always fits the 8-bit signed error.
  always_comb begin
    if (div_quot > NUM_W'(PERCENT_FULL)) begin
      position = PERCENT_FULL;
    end else begin
      position = div_quot[6:0];
    end
    err_next = ERR_W'($signed({2'b00, ref_q}) - $signed({2'b00, position}));
  end

  // Evaluation: the proportional product is moved from Q.16 to Q.24 and added to the
  // integral product. Outside the strict limits the drive clamps to exactly plus or minus
  // 100; inside, the Q.24 value is cut to Q7.8 by truncation toward zero.
  logic signed [U_W-1:0]     u_sum;
  logic signed [U_W-1:0]     lim_pos;
  logic signed [U_W-1:0]     lim_neg;
  logic signed [U_W-1:0]     u_adj;
  logic                      sat_hi;
  logic                      sat_lo;
  logic                      sat;
  logic signed [DRIVE_W-1:0] drive_next;

  always_comb begin
    u_sum   = (U_W'(prod_p) <<< 8) + U_W'(prod_i);
    lim_pos = U_W'(LIMIT_Q24);
    lim_neg = -lim_pos;
    sat_hi  = (u_sum > lim_pos);
    sat_lo  = (u_sum < lim_neg);
    sat     = sat_hi || sat_lo;
    u_adj   = u_sum + (u_sum[U_W-1] ? U_W'(16'hFFFF) : U_W'(0));
    if (sat_hi) begin
      drive_next = DRIVE_MAX;
    end else if (sat_lo) begin
      drive_next = DRIVE_MIN;
    end else begin
      drive_next = DRIVE_W'(u_adj >>> 16);
    end
  end

  // When the result clamps, the error just stored is dropped from the ring and the sum.
  assign ring_we    = (state == ST_EVAL) && out_free;
  assign ring_wdata = sat ? '0 : err;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (sample_xfer) state_next = ST_DIV;
      ST_DIV:  if (div_done)    state_next = ST_ERR;
      ST_ERR:                   state_next = ST_MULI;
      ST_MULI:                  state_next = ST_EVAL;
      ST_EVAL: if (out_free)    state_next = ST_IDLE;
      default:                  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_sum   <= '0;
      write_index  <= '0;
      ring_valid   <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (result_xfer && !ring_we) begin
        result.valid <= 1'b0;
      end
      if (state == ST_ERR) begin
        window_sum <= window_sum - SUM_W'(old_err) + SUM_W'(err);
      end
      if (ring_we) begin
        result.valid            <= 1'b1;
        ring_valid[write_index] <= 1'b1;
        if (sat) begin
          window_sum <= window_sum - SUM_W'(err);
        end
        if (write_index == IDX_W'(WINDOW_DEPTH - 1)) begin
          write_index <= '0;
        end else begin
          write_index <= write_index + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      ref_q <= sample.reference;
    end
    if ((state == ST_DIV) && div_done) begin
      err <= err_next;
    end
    if (state == ST_ERR) begin
      prod_p <= P_W'($signed({1'b0, prop_gain}) * err);
    end
    if (state == ST_MULI) begin
      prod_i <= I_W'($signed({1'b0, int_gain}) * window_sum);
    end
    if (ring_we) begin
      result.drive     <= drive_next;
      result.saturated <= sat;
    end
  end

  // A saturated result carries exactly one of the two clamp values.
  a_sat_drive: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.saturated) |->
      (result.drive == DRIVE_MAX || result.drive == DRIVE_MIN))
    else $error("saturated result without a clamp value");

  // An unsaturated result stays within the clamp range.
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.saturated) |->
      (result.drive <= DRIVE_MAX && result.drive >= DRIVE_MIN))
    else $error("drive outside the clamp range");

  // The window sum never exceeds what a full ring of extreme errors can hold.
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    (int'(window_sum) <= WINDOW_DEPTH * 127) && (int'(window_sum) >= -(WINDOW_DEPTH * 128)))
    else $error("window sum out of range");

  // The controller takes no sample while the divider is still working.
  a_ready_div: assert property (@(posedge clk) disable iff (rst)
    sample.ready |-> !div_busy)
    else $error("sample accepted while the divider is busy");

  // The write pointer advances only when a result is formed.
  a_ptr_step: assert property (@(posedge clk) disable iff (rst)
    !$past(ring_we) |-> $stable(write_index))
    else $error("write pointer moved without a result");

endmodule
`default_nettype wire

// ===== sv/piwa_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the position scaling.
`timescale 1ns / 1ps
`default_nettype none
module piwa_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [piwa_pkg::NUM_W-1:0]   num,
  input  wire logic [piwa_pkg::COUNT_W-1:0] den,
  output logic                              busy,
  output logic                              done,
  output logic [piwa_pkg::NUM_W-1:0]        quot
);
  import piwa_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [CNT_W-1:0]   cnt;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W:0]   rem_sh;
  logic               q_bit;
  logic [COUNT_W-1:0] rem_next;

  // The partial remainder stays below the divisor, so the shifted value fits one extra bit.
  always_comb begin
    rem_sh = {rem, quot[NUM_W-1]};
    q_bit  = (rem_sh >= {1'b0, den});
    if (q_bit) begin
      rem_next = COUNT_W'(rem_sh - {1'b0, den});
    end else begin
      rem_next = rem_sh[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= {quot[NUM_W-2:0], q_bit};
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the windowed-integral PI controller core.
`timescale 1ns / 1ps
module testbench;
  import piwa_pkg::*;

  // The ring depth must match the parameter given to the core below.
  localparam int RING_DEPTH = 50;

  // The longest quiet stretch in a correct run is the deliberate receiver hold-off of
  // PRESSURE_CYCLES. Random stalls and gaps are much shorter, so the watchdog limit
  // leaves a wide margin over both.
  localparam int QUIET_LIMIT     = 5000;
  localparam int PRESSURE_CYCLES = 300;
  // The final drain allows a little more than the core needs for one sample.
  localparam int DRAIN_CYCLES    = 40;
  localparam int MAX_REPORTS     = 40;

  // Index 3 is not a register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [COUNT_W-1:0]   COUNT_MAX  = '1;
  localparam logic [GAIN_W-1:0]    GAIN_MAX   = '1;
  localparam logic [GAIN_W-1:0]    GAIN_ONE   = 24'h010000;

  typedef struct packed {
    logic [REF_W-1:0]   reference;
    logic [COUNT_W-1:0] encoder_count;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      saturated;
  } drive_result_t;

  // Traffic shapes: how often the sender leaves a gap and the receiver stalls.
  typedef enum int {
    FLOW_STEADY,
    FLOW_SENDER_GAPS,
    FLOW_RECEIVER_STALLS,
    FLOW_BOTH_IDLE
  } flow_mode_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  piwa_in_if  sample_ch ();
  piwa_out_if result_ch ();

  pi_windowed_integral_antiwindup_core #(
    .WINDOW_DEPTH(RING_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample_ch.sink),
    .result   (result_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Controller state as the testbench tracks it. The register copies follow every
  // write seen on the configuration port, and the ring, slot and sum follow every
  // accepted sample transfer.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0]      full_scale_q;
  logic [GAIN_W-1:0]       prop_gain_q;
  logic [GAIN_W-1:0]       int_gain_q;
  logic signed [ERR_W-1:0] error_ring [RING_DEPTH];
  int                      ring_slot;
  int                      window_total;

  drive_result_t pending_drives [$];
  int            fail_count    = 0;
  int            quiet_cycles  = 0;
  int            hold_off_left = 0;
  flow_mode_t    flow_mode     = FLOW_STEADY;

  function automatic void clear_controller();
    full_scale_q = FULL_SCALE_RST;
    prop_gain_q  = PROP_GAIN_RST;
    int_gain_q   = INT_GAIN_RST;
    foreach (error_ring[i]) error_ring[i] = '0;
    ring_slot    = 0;
    window_total = 0;
  endfunction

  // Works out the drive for one sample and advances the ring exactly as the core must.
  function automatic drive_result_t predict_drive(sample_t s);
    longint unsigned divisor;
    longint unsigned scaled;
    longint          kp;
    longint          ki;
    longint          u;
    longint          mag;
    int              position;
    int              err;
    drive_result_t   r;
    // A full scale of zero behaves as one, so any nonzero count reads as full travel.
    divisor  = (full_scale_q == '0) ? 64'd1 : 64'(full_scale_q);
    scaled   = 64'(s.encoder_count) * 64'd100 / divisor;
    position = (scaled > 64'd100) ? 100 : int'(scaled);
    err      = int'(s.reference) - position;

    // The slot being overwritten leaves the window sum, the new error enters it.
    window_total = window_total - error_ring[ring_slot] + err;
    error_ring[ring_slot] = err[ERR_W-1:0];

    // Proportional term is Q.16, lifted to Q.24 to line up with the integral term.
    kp = prop_gain_q;
    ki = int_gain_q;
    u  = kp * err * 256 + ki * window_total;

    r.saturated = 1'b0;
    if (u > longint'(LIMIT_Q24)) begin
      r.saturated = 1'b1;
      r.drive     = DRIVE_MAX;
    end else if (u < -longint'(LIMIT_Q24)) begin
      r.saturated = 1'b1;
      r.drive     = DRIVE_MIN;
    end else begin
      // Q.24 to Q7.8, truncating toward zero on both sides.
      mag     = ((u < 0) ? -u : u) >> 16;
      r.drive = (u < 0) ? DRIVE_W'(-mag) : DRIVE_W'(mag);
    end

    // Anti-windup: a clamped sample does not stay in the integral window.
    if (r.saturated) begin
      window_total = window_total - error_ring[ring_slot];
      error_ring[ring_slot] = '0;
    end
    ring_slot = (ring_slot + 1) % RING_DEPTH;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge; inputs only ever change at the
  // falling edge, so no sample here can race with the core's own updates. A result
  // transfer is checked before a sample transfer at the same edge is predicted, so a
  // new expectation can never be matched against an older result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor_blk
    sample_t       seen;
    drive_result_t got;
    drive_result_t want;
    if (rst) begin
      clear_controller();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FULL_SCALE: full_scale_q = cfg_data[COUNT_W-1:0];
          CFG_PROP_GAIN:  prop_gain_q  = cfg_data[GAIN_W-1:0];
          CFG_INT_GAIN:   int_gain_q   = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (result_ch.valid && result_ch.ready) begin
        got.drive     = result_ch.drive;
        got.saturated = result_ch.saturated;
        if (pending_drives.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result: expected none, actual drive %0d saturated %0b",
                     $time, got.drive, got.saturated);
        end else begin
          want = pending_drives.pop_front();
          if (got.drive !== want.drive) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: drive mismatch: expected %0d, actual %0d",
                       $time, want.drive, got.drive);
          end
          if (got.saturated !== want.saturated) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: saturated mismatch: expected %0b, actual %0b",
                       $time, want.saturated, got.saturated);
          end
        end
      end

      if (sample_ch.valid && sample_ch.ready) begin
        seen.reference     = sample_ch.reference;
        seen.encoder_count = sample_ch.encoder_count;
        pending_drives.push_back(predict_drive(seen));
      end
    end
  end

  // Watchdog: counts consecutive cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int idle_pct(flow_mode_t mode, bit sender_side);
    case (mode)
      FLOW_SENDER_GAPS:     return sender_side ? 65 : 0;
      FLOW_RECEIVER_STALLS: return sender_side ? 0 : 65;
      FLOW_BOTH_IDLE:       return 7;
      default:              return 0;
    endcase
  endfunction

  // Receiver. A pending hold-off keeps ready low for its whole length, otherwise the
  // current traffic shape decides cycle by cycle whether the result side stalls.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= idle_pct(flow_mode, 1'b0));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left just after a falling edge.
  // ---------------------------------------------------------------------------

  // Offers one sample, possibly after a random gap, and returns once it has been taken.
  // Valid is left high on return, so it drops between samples only for a random gap.
  task automatic send_sample(input logic [REF_W-1:0] ref_pct,
                             input logic [COUNT_W-1:0] count);
    int gap_pct;
    gap_pct = idle_pct(flow_mode, 1'b1);
    while ($urandom_range(99) < gap_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.reference     <= ref_pct;
    sample_ch.encoder_count <= count;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted result has been checked. As every
  // sample yields a result, the core is idle by then; a short spare wait follows.
  task automatic wait_until_idle();
    sample_ch.valid <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki);
    write_register(CFG_PROP_GAIN, kp);
    write_register(CFG_INT_GAIN, ki);
  endtask

  // Encoder count that reads as the given position in thousandths of a percent,
  // taken against the full scale currently programmed.
  function automatic logic [COUNT_W-1:0] count_at_milli(int milli);
    longint fs;
    longint c;
    fs = (full_scale_q == '0) ? 1 : longint'(full_scale_q);
    c  = fs * ((milli < 0) ? 0 : milli) / 100000;
    return (c > longint'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(c);
  endfunction

  function automatic logic [REF_W-1:0] random_reference();
    if ($urandom_range(15) == 0)
      return REF_W'($urandom_range(127, 101));
    return REF_W'($urandom_range(100, 0));
  endfunction

  function automatic logic [COUNT_W-1:0] random_count();
    if ($urandom_range(3) == 0)
      return COUNT_W'($urandom());
    // Mostly within travel, with some counts past full scale.
    return count_at_milli($urandom_range(112500, 0));
  endfunction

  task automatic pick_random_settings();
    logic [COUNT_W-1:0] fs;
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    case ($urandom_range(7))
      0:       fs = COUNT_W'($urandom_range(1, 0));
      1:       fs = COUNT_MAX;
      2:       fs = COUNT_W'($urandom_range(4095, 1));
      default: fs = COUNT_W'($urandom_range(COUNT_MAX, 1));
    endcase
    case ($urandom_range(7))
      0:       kp = '0;
      1:       kp = GAIN_MAX;
      2:       kp = GAIN_W'($urandom());
      default: kp = GAIN_W'($urandom_range(4 * GAIN_ONE, 0));
    endcase
    case ($urandom_range(7))
      0:       ki = '0;
      1:       ki = GAIN_MAX;
      2:       ki = GAIN_W'($urandom_range(1 << 20, 0));
      default: ki = GAIN_W'($urandom_range(1 << 23, 0));
    endcase
    // Bits above the 20-bit full scale are junk and must be dropped by the core.
    write_register(CFG_FULL_SCALE, {4'($urandom()), fs});
    set_gains(kp, ki);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset values: default full scale and gains, ring empty.
  task automatic test_default_settings();
    flow_mode = FLOW_STEADY;
    send_sample(7'd0, '0);
    send_sample(7'd100, '0);
    send_sample(7'd0, COUNT_MAX);
    send_sample(7'd127, '0);
    send_sample(7'd10, '0);
    send_sample(7'd50, 20'd524288);
    wait_until_idle();
  endtask

  // Smallest full scales, zero full scale, counts beyond full scale, and a write to an
  // index that holds no register.
  task automatic test_full_scale_cases();
    flow_mode = FLOW_STEADY;
    write_register(CFG_FULL_SCALE, {4'hF, 20'd1});
    write_register(CFG_PROP_GAIN, GAIN_ONE);
    send_sample(7'd0, 20'd1);
    send_sample(7'd100, '0);
    send_sample(7'd100, COUNT_MAX);
    send_sample(7'd127, 20'd2);
    wait_until_idle();

    write_register(CFG_FULL_SCALE, '0);
    send_sample(7'd20, '0);
    send_sample(7'd20, 20'd1);
    wait_until_idle();

    write_register(CFG_FULL_SCALE, 24'd1000);
    send_sample(7'd60, 20'd1001);
    send_sample(7'd60, 20'd999);
    wait_until_idle();
    write_register(CFG_UNUSED, '1);
    send_sample(7'd30, 20'd500);
    wait_until_idle();
  endtask

  // Gains at both ends of their range, including both at zero.
  task automatic test_gain_extremes();
    flow_mode = FLOW_STEADY;
    write_register(CFG_FULL_SCALE, CFG_DATA_W'(COUNT_MAX));
    set_gains('0, GAIN_MAX);
    send_sample(7'd5, '0);
    send_sample(7'd127, '0);
    send_sample(7'd0, COUNT_MAX);
    wait_until_idle();

    set_gains(GAIN_MAX, '0);
    send_sample(7'd1, '0);
    send_sample(7'd50, 20'd524288);
    wait_until_idle();

    set_gains('0, '0);
    send_sample(7'd100, '0);
    send_sample(7'd0, COUNT_MAX);
    wait_until_idle();
  endtask

  // One randomised phase. Most bursts track a held reference with the position close
  // to it, so the integral window fills with small errors and the clamp is hit only
  // now and then; the rest are unrelated samples that mostly saturate.
  task automatic run_random_phase(input flow_mode_t mode, input int item_goal);
    int             sent;
    int             burst;
    logic [REF_W-1:0] held_ref;
    flow_mode = mode;
    pick_random_settings();
    sent = 0;
    while (sent < item_goal) begin
      burst = $urandom_range(60, 1);
      if ($urandom_range(3) != 0) begin
        held_ref = REF_W'($urandom_range(100, 0));
        repeat (burst)
          send_sample(held_ref,
                      count_at_milli(int'(held_ref) * 1000 +
                                     int'($urandom_range(16000, 0)) - 8000));
      end else begin
        repeat (burst) send_sample(random_reference(), random_count());
      end
      sent += burst;
    end
    wait_until_idle();
  endtask

  // Every traffic shape twice, each time under fresh register settings.
  task automatic test_random_sweep();
    for (int phase = 0; phase < 8; phase++)
      run_random_phase(flow_mode_t'(phase % 4), 95);
  endtask

  // The receiver refuses results for a long stretch while samples keep coming, so the
  // core fills up and has to hold its sample channel off.
  task automatic test_backpressure();
    flow_mode = FLOW_STEADY;
    pick_random_settings();
    hold_off_left = PRESSURE_CYCLES;
    repeat (12) send_sample(random_reference(), random_count());
    wait_until_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  initial begin
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    sample_ch.valid         = 1'b0;
    sample_ch.reference     = '0;
    sample_ch.encoder_count = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_settings();
    test_full_scale_cases();
    test_gain_extremes();
    test_random_sweep();
    test_backpressure();

    // Give any stray late result time to show up before the verdict.
    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_drives.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/piwa_pkg.sv
sv/piwa_if.sv
sv/piwa_divider.sv
sv/pi_windowed_integral_antiwindup_core.sv
tb/sv/testbench.sv
